// File: rtl/swdr_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types of the swipe direction recognizer.
// No dependencies; every other file of the block imports it.
package swdr_pkg;

	localparam int MAX_TRACKS = 8;
	localparam int TRK_IDX_W  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;

	localparam int TID_W  = 3;
	localparam int TIME_W = 32;
	localparam int POS_W  = 16;
	localparam int DIR_W  = 3;
	localparam int CNT_W  = 16;

	localparam int MM_W      = 16;
	localparam int MV_W      = 12;
	localparam int MD_W      = 24;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 2;

	// serial multiplier: A operand, B operand consumed DIG_W bits per cycle
	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 28;
	localparam int PROD_W  = 64;
	localparam int DIG_W   = 4;
	localparam int LHS_W   = 54;

	localparam logic [DIR_W-1:0] DIR_NONE  = 3'd0;
	localparam logic [DIR_W-1:0] DIR_UP    = 3'd1;
	localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd2;
	localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd3;
	localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_MOVEMENT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_VELOCITY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DURATION = 2'd2;

	localparam logic [MM_W-1:0] MIN_MOVEMENT_RST = 16'd800;
	localparam logic [MV_W-1:0] MIN_VELOCITY_RST = 12'd5;
	localparam logic [MD_W-1:0] MAX_DURATION_RST = 24'd500000;

	// us to ms scale, squared
	localparam logic [MUL_B_W-1:0] VEL_SCALE = 28'd1000000;
	// speed products above this can never pass
	localparam logic [PROD_W-1:0]  VEL_LIMIT = 64'h0000_0000_0800_0000;

	typedef logic [TRK_IDX_W-1:0] trk_idx_t;

	typedef struct packed {
		logic clear;
		logic set_seen;
		logic set_ended;
		logic set_can;
		logic wr_start;
		logic wr_prev;
	} trk_wr_t;

	typedef struct packed {
		logic              seen;
		logic              ended;
		logic              can;
		logic [POS_W-1:0]  start_x;
		logic [POS_W-1:0]  start_y;
		logic [TIME_W-1:0] start_time;
		logic [POS_W-1:0]  prev_x;
		logic [POS_W-1:0]  prev_y;
		logic [TIME_W-1:0] prev_time;
	} trk_ent_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_MOVE_X,
		S_MOVE_Y,
		S_MOVE_T,
		S_STEP_X,
		S_STEP_Y,
		S_VEL,
		S_LHS,
		S_RHS,
		S_COMMIT,
		S_FINISH
	} state_t;

endpackage

// File: rtl/swdr_mul.sv
`timescale 1ns / 1ps
// Digit-serial shift-add multiplier, DIG_W bits of B per cycle, stops early.
// Depends on swdr_pkg.
module swdr_mul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [swdr_pkg::MUL_A_W-1:0] a,
	input  logic [swdr_pkg::MUL_B_W-1:0] b,
	output logic                         busy,
	output logic [swdr_pkg::PROD_W-1:0]  prod
);
	import swdr_pkg::*;

	logic                busy_q;
	logic [PROD_W-1:0]   a_q;
	logic [PROD_W-1:0]   acc_q;
	logic [MUL_B_W-1:0]  b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && ((b_q >> DIG_W) == '0)) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= PROD_W'(a);
			b_q   <= b;
		end else if (busy_q) begin
			acc_q <= acc_q + (a_q * PROD_W'(b_q[DIG_W-1:0]));
			a_q   <= a_q << DIG_W;
			b_q   <= b_q >> DIG_W;
		end
	end

	assign busy = busy_q;
	assign prod = acc_q;

endmodule

// File: rtl/swdr_track.sv
`timescale 1ns / 1ps
// Per-track store: seen/ended/can-swipe flags plus start and previous point.
// Depends on swdr_pkg.
module swdr_track (
	input  logic                        clk,
	input  logic                        arst_n,
	input  swdr_pkg::trk_idx_t          idx,
	input  swdr_pkg::trk_wr_t           wr,
	input  logic [swdr_pkg::POS_W-1:0]  x,
	input  logic [swdr_pkg::POS_W-1:0]  y,
	input  logic [swdr_pkg::TIME_W-1:0] now,
	output swdr_pkg::trk_ent_t          ent
);
	import swdr_pkg::*;

	logic [MAX_TRACKS-1:0] seen_q;
	logic [MAX_TRACKS-1:0] ended_q;
	logic [MAX_TRACKS-1:0] can_q;

	logic [POS_W-1:0]  start_x_q    [MAX_TRACKS];
	logic [POS_W-1:0]  start_y_q    [MAX_TRACKS];
	logic [TIME_W-1:0] start_time_q [MAX_TRACKS];
	logic [POS_W-1:0]  prev_x_q     [MAX_TRACKS];
	logic [POS_W-1:0]  prev_y_q     [MAX_TRACKS];
	logic [TIME_W-1:0] prev_time_q  [MAX_TRACKS];

	// flags clear at reset and at end of trial
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			ended_q <= '0;
			can_q   <= '0;
		end else if (wr.clear) begin
			seen_q  <= '0;
			ended_q <= '0;
			can_q   <= '0;
		end else begin
			if (wr.set_seen) seen_q[idx] <= 1'b1;
			if (wr.set_ended) ended_q[idx] <= 1'b1;
			if (wr.set_can) can_q[idx] <= 1'b1;
		end
	end

	// point data is only read after a write in the same trial
	always_ff @(posedge clk) begin
		if (wr.wr_start) begin
			start_x_q[idx]    <= x;
			start_y_q[idx]    <= y;
			start_time_q[idx] <= now;
		end
		if (wr.wr_prev) begin
			prev_x_q[idx]    <= x;
			prev_y_q[idx]    <= y;
			prev_time_q[idx] <= now;
		end
	end

	always_comb begin
		ent.seen       = seen_q[idx];
		ent.ended      = ended_q[idx];
		ent.can        = can_q[idx];
		ent.start_x    = start_x_q[idx];
		ent.start_y    = start_y_q[idx];
		ent.start_time = start_time_q[idx];
		ent.prev_x     = prev_x_q[idx];
		ent.prev_y     = prev_y_q[idx];
		ent.prev_time  = prev_time_q[idx];
	end

endmodule

// File: rtl/swipe_direction_recognizer.sv
`timescale 1ns / 1ps
// Swipe direction recognizer, top level: sequencer, datapath, output register.
// Depends on swdr_pkg, swdr_mul and swdr_track.
//
// Usage:
//  - Config: cfg_we writes cfg_data into register cfg_index (0 min_movement,
//    1 min_velocity, 2 max_duration) at the clock edge; write only when idle.
//  - Input requests (valid/ready) carry either a touch point (action 0) or
//    an end-of-trial with target_direction (action 1).
//  - Every request yields exactly one result request: direction, success,
//    success_count, held in an output register until out_ready.
//  - Path: end of trial, ignored, ended, first or timed-out points go from
//    LOAD straight to FINISH; other points run the serial multiplier, which
//    retires 4 bits of its B operand per cycle and runs up to 8 products
//    per point (start distance squared, squared movement threshold, step
//    distance squared, speed product and the two squared speed terms).
//  - Throughput: one request at a time, as in_ready is high only in IDLE.
//    The next request is taken while a result still waits in the output
//    register; a stalled receiver holds the block in its final state until
//    the register frees up.
//  - Reset: trial state, flags and success count clear, registers take their
//    defaults (800, 5, 500000). Point data per track is written before use.
module swipe_direction_recognizer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [swdr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [swdr_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           action,
	input  logic [swdr_pkg::TID_W-1:0]     track_id,
	input  logic [swdr_pkg::TIME_W-1:0]    time_us,
	input  logic [swdr_pkg::POS_W-1:0]     pos_x,
	input  logic [swdr_pkg::POS_W-1:0]     pos_y,
	input  logic                           last_point,
	input  logic [swdr_pkg::DIR_W-1:0]     target_direction,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [swdr_pkg::DIR_W-1:0]     direction,
	output logic                           success,
	output logic [swdr_pkg::CNT_W-1:0]     success_count
);
	import swdr_pkg::*;

	// sequencer
	state_t state_q, state_d;
	logic   enter_q;          // first cycle in a state

	// request captured at accept
	logic              action_q;
	logic [TID_W-1:0]  tid_q;
	logic [TIME_W-1:0] time_q;
	logic [POS_W-1:0]  x_q;
	logic [POS_W-1:0]  y_q;
	logic              last_q;
	logic [DIR_W-1:0]  target_q;

	// config registers
	logic [MM_W-1:0] min_mov_q;
	logic [MV_W-1:0] min_vel_q;
	logic [MD_W-1:0] max_dur_q;

	// trial state
	logic [DIR_W-1:0] dir_q;
	logic             any_seen_q;
	logic [CNT_W-1:0] succ_total_q;

	// working registers
	logic [POS_W-1:0]   st_ax_q, st_ay_q;   // offset from track start
	logic [POS_W-1:0]   mv_ax_q, mv_ay_q;   // step from previous point
	logic [TIME_W-1:0]  dt_p_q;
	logic [DIR_W-1:0]   cand_dir_q;
	logic               hit_q;
	logic               can_q;
	logic               succ_q;
	logic [MUL_A_W-1:0] sum_q;
	logic [MUL_B_W-1:0] m_q;
	logic [LHS_W-1:0]   lhs_q;

	// output register
	logic             out_valid_q;
	logic [DIR_W-1:0] out_dir_q;
	logic             out_succ_q;
	logic [CNT_W-1:0] out_cnt_q;

	// datapath wires
	trk_ent_t           ent;
	trk_wr_t            tw;
	trk_idx_t           trk_idx;
	logic               accept, emit, in_range, first, timeout;
	logic               mul_start, mul_busy, mul_done, move_ok, vel_over, fast;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0]  mul_prod;
	logic [TIME_W-1:0]  start_t_eff, age;
	logic [POS_W:0]     st_dx, st_dy, mv_dx, mv_dy;
	logic [POS_W-1:0]   mv_ax, mv_ay;
	logic [DIR_W-1:0]   cand_dir;

	// magnitude of a 17-bit two's complement difference; always fits 16 bits
	function automatic logic [POS_W-1:0] mag(input logic [POS_W:0] v);
		logic [POS_W:0] n;
		n = -v;
		return v[POS_W] ? n[POS_W-1:0] : v[POS_W-1:0];
	endfunction

	assign accept   = in_valid && in_ready;
	assign emit     = (state_q == S_FINISH) && (!out_valid_q || out_ready);
	assign in_range = int'(tid_q) < MAX_TRACKS;
	assign trk_idx  = TRK_IDX_W'(tid_q);
	assign first    = !ent.seen;

	// timeout: a first point measures against its own timestamp
	assign start_t_eff = first ? time_q : ent.start_time;
	assign age         = time_q - start_t_eff;
	assign timeout     = age >= TIME_W'(max_dur_q);

	assign st_dx = {x_q[POS_W-1], x_q} - {ent.start_x[POS_W-1], ent.start_x};
	assign st_dy = {y_q[POS_W-1], y_q} - {ent.start_y[POS_W-1], ent.start_y};
	assign mv_dx = {x_q[POS_W-1], x_q} - {ent.prev_x[POS_W-1], ent.prev_x};
	assign mv_dy = {y_q[POS_W-1], y_q} - {ent.prev_y[POS_W-1], ent.prev_y};
	assign mv_ax = mag(mv_dx);
	assign mv_ay = mag(mv_dy);

	// dominant axis of the step; vertical wins ties, no motion gives none
	always_comb begin
		cand_dir = DIR_NONE;
		if (mv_ay >= mv_ax) begin
			if (mv_dy[POS_W]) begin
				cand_dir = DIR_UP;
			end else if (mv_dy != '0) begin
				cand_dir = DIR_DOWN;
			end
		end else begin
			cand_dir = mv_dx[POS_W] ? DIR_LEFT : DIR_RIGHT;
		end
	end

	assign mul_done = !enter_q && !mul_busy;
	assign move_ok  = ent.can || (sum_q >= MUL_A_W'(mul_prod[2*MM_W-1:0]));
	assign vel_over = mul_prod > VEL_LIMIT;
	assign fast     = PROD_W'(lhs_q) >= mul_prod;

	swdr_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.prod   (mul_prod)
	);

	swdr_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.idx    (trk_idx),
		.wr     (tw),
		.x      (x_q),
		.y      (y_q),
		.now    (time_q),
		.ent    (ent)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_LOAD;
			end
			S_LOAD: begin
				if (action_q || !in_range || ent.ended || timeout || first) begin
					state_d = S_FINISH;
				end else begin
					state_d = S_MOVE_X;
				end
			end
			S_MOVE_X: begin
				if (mul_done) state_d = S_MOVE_Y;
			end
			S_MOVE_Y: begin
				if (mul_done) state_d = S_MOVE_T;
			end
			S_MOVE_T: begin
				if (mul_done) state_d = move_ok ? S_STEP_X : S_COMMIT;
			end
			S_STEP_X: begin
				if (mul_done) state_d = S_STEP_Y;
			end
			S_STEP_Y: begin
				if (mul_done) state_d = S_VEL;
			end
			S_VEL: begin
				if (mul_done) state_d = vel_over ? S_COMMIT : S_LHS;
			end
			S_LHS: begin
				if (mul_done) state_d = S_RHS;
			end
			S_RHS: begin
				if (mul_done) state_d = S_COMMIT;
			end
			S_COMMIT: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (emit) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// sequencer outputs: handshake, multiplier operands, track writes
	always_comb begin
		in_ready  = 1'b0;
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		tw        = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
			end
			S_LOAD: begin
				if (!action_q && in_range && !ent.ended) begin
					tw.set_seen  = first;
					tw.wr_start  = first;
					tw.set_ended = timeout || (first && last_q);
					tw.wr_prev   = first && !timeout;
				end
			end
			S_MOVE_X: begin
				mul_start = enter_q;
				mul_a     = MUL_A_W'(st_ax_q);
				mul_b     = MUL_B_W'(st_ax_q);
			end
			S_MOVE_Y: begin
				mul_start = enter_q;
				mul_a     = MUL_A_W'(st_ay_q);
				mul_b     = MUL_B_W'(st_ay_q);
			end
			S_MOVE_T: begin
				mul_start = enter_q;
				mul_a     = MUL_A_W'(min_mov_q);
				mul_b     = MUL_B_W'(min_mov_q);
			end
			S_STEP_X: begin
				mul_start = enter_q;
				mul_a     = MUL_A_W'(mv_ax_q);
				mul_b     = MUL_B_W'(mv_ax_q);
			end
			S_STEP_Y: begin
				mul_start = enter_q;
				mul_a     = MUL_A_W'(mv_ay_q);
				mul_b     = MUL_B_W'(mv_ay_q);
			end
			S_VEL: begin
				mul_start = enter_q;
				mul_a     = MUL_A_W'(dt_p_q);
				mul_b     = MUL_B_W'(min_vel_q);
			end
			S_LHS: begin
				mul_start = enter_q;
				mul_a     = sum_q;
				mul_b     = VEL_SCALE;
			end
			S_RHS: begin
				mul_start = enter_q;
				mul_a     = MUL_A_W'(m_q);
				mul_b     = m_q;
			end
			S_COMMIT: begin
				tw.wr_prev   = 1'b1;
				tw.set_can   = can_q;
				tw.set_ended = last_q || hit_q;
			end
			S_FINISH: begin
				tw.clear = emit && action_q;
			end
			default: ;
		endcase
	end

	// control and trial state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			enter_q      <= 1'b0;
			min_mov_q    <= MIN_MOVEMENT_RST;
			min_vel_q    <= MIN_VELOCITY_RST;
			max_dur_q    <= MAX_DURATION_RST;
			dir_q        <= DIR_NONE;
			any_seen_q   <= 1'b0;
			succ_total_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			enter_q <= state_d != state_q;

			if (cfg_we) begin
				case (cfg_index)
					REG_MIN_MOVEMENT: min_mov_q <= cfg_data[MM_W-1:0];
					REG_MIN_VELOCITY: min_vel_q <= cfg_data[MV_W-1:0];
					REG_MAX_DURATION: max_dur_q <= cfg_data[MD_W-1:0];
					default: ;
				endcase
			end

			case (state_q)
				S_LOAD: begin
					if (action_q) begin
						if (any_seen_q && (target_q == dir_q) && (succ_total_q != '1)) begin
							succ_total_q <= succ_total_q + 1'b1;
						end
					end else if (in_range) begin
						any_seen_q <= 1'b1;
						if (!ent.ended && timeout) dir_q <= DIR_NONE;
					end
				end
				S_COMMIT: begin
					if (hit_q) dir_q <= cand_dir_q;
				end
				S_FINISH: begin
					// trial clears as its result leaves
					if (emit && action_q) begin
						dir_q      <= DIR_NONE;
						any_seen_q <= 1'b0;
					end
				end
				default: ;
			endcase

			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload and working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action;
			tid_q    <= track_id;
			time_q   <= time_us;
			x_q      <= pos_x;
			y_q      <= pos_y;
			last_q   <= last_point;
			target_q <= target_direction;
		end

		case (state_q)
			S_LOAD: begin
				st_ax_q    <= mag(st_dx);
				st_ay_q    <= mag(st_dy);
				mv_ax_q    <= mv_ax;
				mv_ay_q    <= mv_ay;
				dt_p_q     <= time_q - ent.prev_time;
				cand_dir_q <= cand_dir;
				hit_q      <= 1'b0;
				can_q      <= ent.can;
				succ_q     <= action_q && any_seen_q && (target_q == dir_q);
			end
			S_MOVE_X, S_STEP_X: begin
				if (mul_done) sum_q <= mul_prod[MUL_A_W-1:0];
			end
			S_MOVE_Y, S_STEP_Y: begin
				if (mul_done) sum_q <= sum_q + mul_prod[MUL_A_W-1:0];
			end
			S_MOVE_T: begin
				if (mul_done) can_q <= move_ok;
			end
			S_VEL: begin
				if (mul_done) m_q <= mul_prod[MUL_B_W-1:0];
			end
			S_LHS: begin
				if (mul_done) lhs_q <= mul_prod[LHS_W-1:0];
			end
			S_RHS: begin
				if (mul_done) hit_q <= fast && (cand_dir_q != DIR_NONE);
			end
			default: ;
		endcase

		if (emit) begin
			out_dir_q  <= dir_q;
			out_succ_q <= succ_q;
			out_cnt_q  <= succ_total_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign direction     = out_dir_q;
	assign success       = out_succ_q;
	assign success_count = out_cnt_q;

endmodule
